FILE: rtl/core/spsp_pkg.sv
// ----------------------------------------------------------------------------
// Shelf pack sprite placer package
// Shared widths, register indices and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spsp_pkg;

  localparam int unsigned DimW  = 16;
  localparam int unsigned ProdW = 2 * DimW;
  localparam int unsigned CntW  = $clog2(DimW);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DimW-1:0] CapWidthRst   = DimW'(256);
  localparam logic [DimW-1:0] CapHeightRst  = DimW'(256);
  localparam logic [DimW-1:0] AreaWidthRst  = DimW'(1024);
  localparam logic [DimW-1:0] AreaHeightRst = DimW'(1024);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAP_WIDTH   = 2'd0,
    CFG_CAP_HEIGHT  = 2'd1,
    CFG_AREA_WIDTH  = 2'd2,
    CFG_AREA_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic decide;
    logic div_step;
    logic div_last;
    logic shelf;
    logic place;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } status_t;

endpackage

FILE: rtl/core/spsp_ctrl.sv
// ----------------------------------------------------------------------------
// Shelf pack sprite placer controller
// Sequences the multiply, decide, divide, shelf and place steps of one beat
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module spsp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  spsp_pkg::status_t status_i,
  output spsp_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DECIDE,
    ST_DIV,
    ST_SHELF,
    ST_PLACE
  } state_e;

  state_e                      state_q, state_d;
  logic [spsp_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;
  logic                        accept;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        cnt_d        = '0;
        state_d      = status_i.need_div ? ST_DIV : ST_SHELF;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = (cnt_q == '1);
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = ST_SHELF;
        end
      end
      ST_SHELF: begin
        cmd_o.shelf = 1'b1;
        state_d     = ST_PLACE;
      end
      ST_PLACE: begin
        if (out_free) begin
          cmd_o.place = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/spsp_dpath.sv
// ----------------------------------------------------------------------------
// Shelf pack sprite placer datapath
// Holds the configuration registers, the shared multiplier, the radix-2
// restoring divider, the shelf cursor and the result registers.
// ----------------------------------------------------------------------------
module spsp_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  spsp_pkg::cfg_idx_e          cfg_index_i,
  input  logic [spsp_pkg::DimW-1:0]   cfg_data_i,
  input  logic [spsp_pkg::DimW-1:0]   rect_width_i,
  input  logic [spsp_pkg::DimW-1:0]   rect_height_i,
  input  logic                        first_of_set_i,
  input  spsp_pkg::cmd_t              cmd_i,
  output spsp_pkg::status_t           status_o,
  output logic                        placed_o,
  output logic [spsp_pkg::DimW-1:0]   pos_x_o,
  output logic [spsp_pkg::DimW-1:0]   pos_y_o,
  output logic [spsp_pkg::DimW-1:0]   fit_width_o,
  output logic [spsp_pkg::DimW-1:0]   fit_height_o
);

  localparam int unsigned DimW  = spsp_pkg::DimW;
  localparam int unsigned ProdW = spsp_pkg::ProdW;

  logic [DimW-1:0]  cap_w_q, cap_h_q, area_w_q, area_h_q;
  logic [DimW-1:0]  cur_x_q, cur_y_q, shelf_h_q;
  logic [DimW-1:0]  w_q, h_q, fw_q, fh_q, dvsr_q, rem_q, dq_q;
  logic [ProdW-1:0] p0_q, p1_q;
  logic             sel_w_q;

  logic [DimW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] prod;
  logic             in_cap, wide;
  logic [DimW:0]    div_t, div_diff;
  logic             div_ge;
  logic [DimW-1:0]  quot;
  logic [DimW:0]    sum_x, sum_y, sum_sh;

  assign mul_a = cmd_i.mul_a ? w_q : cap_w_q;
  assign mul_b = cmd_i.mul_a ? cap_h_q : h_q;
  assign prod  = mul_a * mul_b;

  assign in_cap = (w_q <= cap_w_q) && (h_q <= cap_h_q);
  assign wide   = (p0_q >= p1_q);
  assign status_o.need_div = !in_cap && (wide ? (w_q != '0) : (h_q != '0));

  assign div_t    = {rem_q, dq_q[DimW-1]};
  assign div_diff = div_t - {1'b0, dvsr_q};
  assign div_ge   = (div_t >= {1'b0, dvsr_q});
  assign quot     = {dq_q[DimW-2:0], div_ge};

  assign sum_x  = {1'b0, cur_x_q} + {1'b0, fw_q};
  assign sum_y  = {1'b0, cur_y_q} + {1'b0, fh_q};
  assign sum_sh = {1'b0, cur_y_q} + {1'b0, shelf_h_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_w_q   <= spsp_pkg::CapWidthRst;
      cap_h_q   <= spsp_pkg::CapHeightRst;
      area_w_q  <= spsp_pkg::AreaWidthRst;
      area_h_q  <= spsp_pkg::AreaHeightRst;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      shelf_h_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          spsp_pkg::CFG_CAP_WIDTH:   cap_w_q  <= cfg_data_i;
          spsp_pkg::CFG_CAP_HEIGHT:  cap_h_q  <= cfg_data_i;
          spsp_pkg::CFG_AREA_WIDTH:  area_w_q <= cfg_data_i;
          spsp_pkg::CFG_AREA_HEIGHT: area_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && first_of_set_i) begin
        cur_x_q   <= '0;
        cur_y_q   <= '0;
        shelf_h_q <= '0;
      end
      if (cmd_i.shelf && (sum_x > {1'b0, area_w_q})) begin
        cur_y_q   <= sum_sh[DimW] ? '1 : sum_sh[DimW-1:0];
        cur_x_q   <= '0;
        shelf_h_q <= '0;
      end
      if (cmd_i.place && (sum_y <= {1'b0, area_h_q})) begin
        cur_x_q <= sum_x[DimW] ? '1 : sum_x[DimW-1:0];
        if (fh_q > shelf_h_q) begin
          shelf_h_q <= fh_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q <= rect_width_i;
      h_q <= rect_height_i;
    end
    if (cmd_i.mul_a) begin
      p0_q <= prod;
    end
    if (cmd_i.mul_b) begin
      p1_q <= prod;
    end
    if (cmd_i.decide) begin
      if (in_cap) begin
        fw_q <= w_q;
        fh_q <= h_q;
      end else if (wide) begin
        fw_q    <= cap_w_q;
        fh_q    <= '0;
        sel_w_q <= 1'b0;
        dvsr_q  <= w_q;
        rem_q   <= p1_q[ProdW-1:DimW];
        dq_q    <= p1_q[DimW-1:0];
      end else begin
        fh_q    <= cap_h_q;
        fw_q    <= '0;
        sel_w_q <= 1'b1;
        dvsr_q  <= h_q;
        rem_q   <= p0_q[ProdW-1:DimW];
        dq_q    <= p0_q[DimW-1:0];
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_diff[DimW-1:0] : div_t[DimW-1:0];
      dq_q  <= quot;
      if (cmd_i.div_last) begin
        if (sel_w_q) begin
          fw_q <= quot;
        end else begin
          fh_q <= quot;
        end
      end
    end
    if (cmd_i.place) begin
      placed_o     <= (sum_y <= {1'b0, area_h_q});
      pos_x_o      <= (sum_y <= {1'b0, area_h_q}) ? cur_x_q : '0;
      pos_y_o      <= (sum_y <= {1'b0, area_h_q}) ? cur_y_q : '0;
      fit_width_o  <= fw_q;
      fit_height_o <= fh_q;
    end
  end

endmodule

FILE: rtl/core/shelf_pack_sprite_placer_unit.sv
// ----------------------------------------------------------------------------
// Shelf pack sprite placer unit
// Scales each rectangle down to the size cap and packs it next-fit on shelves.
// ----------------------------------------------------------------------------
// Sequence: each beat is loaded, multiplied twice and decided, runs through the 16-step divider
// only when it must be downscaled, and is then shelved and placed into the output register.
// A new beat is taken only once the previous beat has been placed; it is taken even while
// the previous result still waits in the output register.
// Reset: cursor and shelf cleared, size cap 256 by 256, area 1024 by 1024.
module shelf_pack_sprite_placer_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [spsp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [spsp_pkg::DimW-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [spsp_pkg::DimW-1:0]            rect_width_i,
  input  logic [spsp_pkg::DimW-1:0]            rect_height_i,
  input  logic                                 first_of_set_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 placed_o,
  output logic [spsp_pkg::DimW-1:0]            pos_x_o,
  output logic [spsp_pkg::DimW-1:0]            pos_y_o,
  output logic [spsp_pkg::DimW-1:0]            fit_width_o,
  output logic [spsp_pkg::DimW-1:0]            fit_height_o
);

  spsp_pkg::cmd_t    cmd;
  spsp_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  spsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spsp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (spsp_pkg::cfg_idx_e'(cfg_index_i)),
    .cfg_data_i     (cfg_data_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .first_of_set_i (first_of_set_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .placed_o       (placed_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .fit_width_o    (fit_width_o),
    .fit_height_o   (fit_height_o)
  );

endmodule

FILE: rtl/core/spsp_checker.sv
// ----------------------------------------------------------------------------
// Shelf pack sprite placer checker
// Port-level assertions on the placer unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module spsp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        placed_o,
  input logic [spsp_pkg::DimW-1:0]   pos_x_o,
  input logic [spsp_pkg::DimW-1:0]   pos_y_o,
  input logic [spsp_pkg::DimW-1:0]   fit_width_o,
  input logic [spsp_pkg::DimW-1:0]   fit_height_o
);

  // A beat that is taken makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // A rejected rectangle reports the origin as its position.
  a_reject_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !placed_o) |-> (pos_x_o == '0 && pos_y_o == '0))
    else $error("rejected rectangle carries a non-zero position");

  // Unless a stalled result is still held, no result is valid in the cycle straight after an input beat is taken.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !(out_valid_o && out_stall_i)) |=> !out_valid_o)
    else $error("result appeared too soon after an input beat");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(placed_o) &&
      $stable(pos_x_o) && $stable(pos_y_o) && $stable(fit_width_o) &&
      $stable(fit_height_o)))
    else $error("stalled result changed");

endmodule

bind shelf_pack_sprite_placer_unit spsp_checker u_spsp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .placed_o     (placed_o),
  .pos_x_o      (pos_x_o),
  .pos_y_o      (pos_y_o),
  .fit_width_o  (fit_width_o),
  .fit_height_o (fit_height_o)
);
